// File: hw/rtl/allpass_diffuser_chain_assert.svh
// Assertion macros for the all-pass diffuser chain.
// Used by the top level only; no other dependencies.
`ifndef ALLPASS_DIFFUSER_CHAIN_ASSERT_SVH
`define ALLPASS_DIFFUSER_CHAIN_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Checked only while out of reset.
`define APD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked at every edge, reset included.
`define APD_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`else

`define APD_ASSERT(name, prop, msg)
`define APD_ASSERT_ALWAYS(name, prop, msg)

`endif

`endif

// File: hw/rtl/apd_pkg.sv
// Shared types and constants of the all-pass diffuser chain.
// No dependencies.
`default_nettype none

package apd_pkg;

  localparam int SAMPLE_W       = 24;
  localparam int GAIN_W         = 16;
  localparam int DELAY_W        = 11;
  localparam int DELAY_MAX      = 2 ** DELAY_W - 1;
  localparam int DELAY_RESET    = 1;
  localparam int NUM_STAGE_REGS = 4;

  // configuration port
  localparam int CFG_IDX_W      = 4;
  localparam int CFG_DATA_W     = 16;
  localparam int REG_DELAY_BASE = 0;
  localparam int REG_GAIN_BASE  = 4;

  // arithmetic widths
  localparam int FRAC_W = 15;
  localparam int PROD_W = SAMPLE_W + GAIN_W;
  localparam int RND_W  = PROD_W + 1 - FRAC_W;
  localparam int ACC_W  = SAMPLE_W + 3;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADDR,
    ST_READ,
    ST_MUL_D,
    ST_SUB,
    ST_MUL_V,
    ST_ADD,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic clr_wr;
    logic load_in;
    logic calc_addr;
    logic rd_en;
    logic mul_d;
    logic sub_v;
    logic mul_v;
    logic wr_v;
    logic add_y;
    logic next_stage;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic last_stage;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// File: hw/rtl/apd_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
`default_nettype none

module apd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 8192
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: hw/rtl/apd_regs.sv
// Configuration registers: per-stage delay length and feedback gain.
// Depends on apd_pkg.
`default_nettype none

module apd_regs #(
  parameter int STAGES = 4
) (
  input  wire logic                                       clk_i,
  input  wire logic                                       rst_ni,
  input  wire logic                                       cfg_we_i,
  input  wire logic [apd_pkg::CFG_IDX_W-1:0]              cfg_idx_i,
  input  wire logic [apd_pkg::CFG_DATA_W-1:0]             cfg_data_i,
  output logic      [STAGES-1:0][apd_pkg::DELAY_W-1:0]    delay_o,
  output logic      [STAGES-1:0][apd_pkg::GAIN_W-1:0]     gain_o
);

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    if (s < apd_pkg::NUM_STAGE_REGS) begin : g_reg
      logic [apd_pkg::DELAY_W-1:0] delay_q;
      logic [apd_pkg::GAIN_W-1:0]  gain_q;

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          delay_q <= apd_pkg::DELAY_W'(apd_pkg::DELAY_RESET);
          gain_q  <= '0;
        end else if (cfg_we_i) begin
          if (cfg_idx_i == apd_pkg::CFG_IDX_W'(apd_pkg::REG_DELAY_BASE + s)) begin
            delay_q <= cfg_data_i[apd_pkg::DELAY_W-1:0];
          end
          if (cfg_idx_i == apd_pkg::CFG_IDX_W'(apd_pkg::REG_GAIN_BASE + s)) begin
            gain_q <= cfg_data_i[apd_pkg::GAIN_W-1:0];
          end
        end
      end

      assign delay_o[s] = delay_q;
      assign gain_o[s]  = gain_q;
    end else begin : g_fixed
      // stages without registers: unit delay, zero gain
      assign delay_o[s] = apd_pkg::DELAY_W'(apd_pkg::DELAY_RESET);
      assign gain_o[s]  = '0;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/apd_ctrl.sv
// Sequencer of the diffuser chain: clearing pass, input accept, per-stage steps.
// Depends on apd_pkg.
`default_nettype none

module apd_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire apd_pkg::sts_t sts_i,
  output apd_pkg::cmd_t      cmd_o
);

  apd_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= apd_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      apd_pkg::ST_CLEAR: if (sts_i.clr_last) state_d = apd_pkg::ST_IDLE;
      apd_pkg::ST_IDLE:  if (in_valid_i) state_d = apd_pkg::ST_ADDR;
      apd_pkg::ST_ADDR:  state_d = apd_pkg::ST_READ;
      apd_pkg::ST_READ:  state_d = apd_pkg::ST_MUL_D;
      apd_pkg::ST_MUL_D: state_d = apd_pkg::ST_SUB;
      apd_pkg::ST_SUB:   state_d = apd_pkg::ST_MUL_V;
      apd_pkg::ST_MUL_V: state_d = apd_pkg::ST_ADD;
      apd_pkg::ST_ADD: begin
        state_d = sts_i.last_stage ? apd_pkg::ST_DONE : apd_pkg::ST_ADDR;
      end
      apd_pkg::ST_DONE:  if (sts_i.out_free) state_d = apd_pkg::ST_IDLE;
      default:           state_d = apd_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      apd_pkg::ST_CLEAR: cmd_o.clr_wr = 1'b1;
      apd_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
      end
      apd_pkg::ST_ADDR:  cmd_o.calc_addr = 1'b1;
      apd_pkg::ST_READ:  cmd_o.rd_en = 1'b1;
      apd_pkg::ST_MUL_D: cmd_o.mul_d = 1'b1;
      apd_pkg::ST_SUB:   cmd_o.sub_v = 1'b1;
      apd_pkg::ST_MUL_V: begin
        cmd_o.mul_v = 1'b1;
        cmd_o.wr_v  = 1'b1;
      end
      apd_pkg::ST_ADD: begin
        cmd_o.add_y      = 1'b1;
        cmd_o.next_stage = !sts_i.last_stage;
      end
      apd_pkg::ST_DONE:  cmd_o.load_out = sts_i.out_free;
      default: begin
        cmd_o      = '0;
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/apd_dp.sv
// Datapath of the diffuser chain: pointers, delay RAM, shared multiplier,
// rounding and saturation, output register. Depends on apd_pkg and apd_ram.
`default_nettype none

module apd_dp #(
  parameter int STAGES     = 4,
  parameter int LINE_DEPTH = 2048
) (
  input  wire logic                                        clk_i,
  input  wire logic                                        rst_ni,
  input  wire apd_pkg::cmd_t                               cmd_i,
  output apd_pkg::sts_t                                    sts_o,
  input  wire logic signed [apd_pkg::SAMPLE_W-1:0]         sample_in_i,
  input  wire logic        [STAGES-1:0][apd_pkg::DELAY_W-1:0] delay_i,
  input  wire logic        [STAGES-1:0][apd_pkg::GAIN_W-1:0]  gain_i,
  input  wire logic                                        out_ready_i,
  output logic                                             out_valid_o,
  output logic        [apd_pkg::SAMPLE_W-1:0]              sample_out_o
);

  localparam int MEM_DEPTH = STAGES * LINE_DEPTH;
  localparam int AW        = $clog2(MEM_DEPTH);
  localparam int PTR_W     = $clog2(LINE_DEPTH);
  localparam int SW        = (STAGES > 1) ? $clog2(STAGES) : 1;
  localparam int SUM_MAX   = LINE_DEPTH - 1 + apd_pkg::DELAY_MAX;
  localparam int SUM_W     = $clog2(SUM_MAX + 1);
  localparam int RED_STEPS = $clog2(SUM_MAX / LINE_DEPTH + 1);
  localparam int RW        = SUM_W + RED_STEPS;

  localparam int SW_SAMPLE = apd_pkg::SAMPLE_W;
  localparam int PW        = apd_pkg::PROD_W;
  localparam int AccW      = apd_pkg::ACC_W;

  localparam logic signed [PW:0]     RND_BIAS = (PW + 1)'(2 ** (apd_pkg::FRAC_W - 1));
  localparam logic signed [AccW-1:0] SAT_HI   = AccW'(2 ** (SW_SAMPLE - 1) - 1);
  localparam logic signed [AccW-1:0] SAT_LO   = -SAT_HI - AccW'(1);

  function automatic logic signed [SW_SAMPLE-1:0] sat(input logic signed [AccW-1:0] a);
    logic signed [SW_SAMPLE-1:0] r;
    if (a > SAT_HI) begin
      r = SAT_HI[SW_SAMPLE-1:0];
    end else if (a < SAT_LO) begin
      r = SAT_LO[SW_SAMPLE-1:0];
    end else begin
      r = a[SW_SAMPLE-1:0];
    end
    return r;
  endfunction

  // control registers
  logic [AW-1:0]    clr_cnt_q;
  logic [PTR_W-1:0] pos_q;
  logic [SW-1:0]    stage_q;
  logic [AW-1:0]    base_q;
  logic             out_valid_q;

  // data registers
  logic [PTR_W-1:0]               rd_idx_q, rd_idx_d;
  logic signed [SW_SAMPLE-1:0]    x_q, d_q, v_q;
  logic signed [PW-1:0]           prod_q, prod_d;
  logic [SW_SAMPLE-1:0]           out_data_q;

  logic [SW_SAMPLE-1:0]           ram_rdata;
  logic signed [SW_SAMPLE-1:0]    mul_a;
  logic signed [apd_pkg::GAIN_W-1:0] gain_sel;
  logic [apd_pkg::DELAY_W-1:0]    delay_sel;
  logic signed [PW:0]             biased;
  logic signed [apd_pkg::RND_W-1:0] rnd;
  logic signed [AccW-1:0]         diff, sum;
  logic [PTR_W-1:0]               pos_dec;
  logic [AW-1:0]                  waddr, raddr;
  logic [RW-1:0]                  rem;

  assign gain_sel  = $signed(gain_i[stage_q]);
  assign delay_sel = delay_i[stage_q];

  // read index = (pos + delay) mod LINE_DEPTH, restoring reduction
  always_comb begin
    rem = RW'(pos_q) + RW'(delay_sel);
    for (int k = RED_STEPS - 1; k >= 0; k--) begin
      if (rem >= (RW'(LINE_DEPTH) << k)) begin
        rem = rem - (RW'(LINE_DEPTH) << k);
      end
    end
    rd_idx_d = rem[PTR_W-1:0];
  end

  // shared multiplier: d*g, then v*g
  assign mul_a  = cmd_i.mul_v ? v_q : $signed(ram_rdata);
  assign prod_d = PW'(mul_a) * PW'(gain_sel);

  // round half up to Q0.23
  assign biased = (PW + 1)'(prod_q) + RND_BIAS;
  assign rnd    = biased[PW:apd_pkg::FRAC_W];
  assign diff   = AccW'(x_q) - AccW'(rnd);
  assign sum    = AccW'(d_q) + AccW'(rnd);

  assign pos_dec = (pos_q == '0) ? PTR_W'(LINE_DEPTH - 1) : pos_q - PTR_W'(1);

  assign waddr = cmd_i.clr_wr ? clr_cnt_q : base_q + AW'(pos_q);
  assign raddr = base_q + AW'(rd_idx_q);

  apd_ram #(
    .WIDTH (SW_SAMPLE),
    .DEPTH (MEM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.clr_wr | cmd_i.wr_v),
    .waddr_i (waddr),
    .wdata_i (cmd_i.clr_wr ? '0 : v_q),
    .re_i    (cmd_i.rd_en),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q   <= '0;
      pos_q       <= '0;
      stage_q     <= '0;
      base_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_wr) begin
        clr_cnt_q <= clr_cnt_q + AW'(1);
      end
      if (cmd_i.load_in) begin
        pos_q   <= pos_dec;
        stage_q <= '0;
        base_q  <= '0;
      end else if (cmd_i.next_stage) begin
        stage_q <= stage_q + SW'(1);
        base_q  <= base_q + AW'(LINE_DEPTH);
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      x_q <= sample_in_i;
    end else if (cmd_i.add_y) begin
      x_q <= sat(sum);
    end
    if (cmd_i.calc_addr) begin
      rd_idx_q <= rd_idx_d;
    end
    if (cmd_i.mul_d) begin
      d_q <= $signed(ram_rdata);
    end
    if (cmd_i.mul_d || cmd_i.mul_v) begin
      prod_q <= prod_d;
    end
    if (cmd_i.sub_v) begin
      v_q <= sat(diff);
    end
    if (cmd_i.load_out) begin
      out_data_q <= x_q;
    end
  end

  assign sts_o.clr_last   = (clr_cnt_q == AW'(MEM_DEPTH - 1));
  assign sts_o.last_stage = (stage_q == SW'(STAGES - 1));
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_data_q;

endmodule

`default_nettype wire

// File: hw/rtl/allpass_diffuser_chain.sv
// Top level of the all-pass diffuser chain: registers, sequencer, datapath.
// Depends on apd_pkg, apd_regs, apd_ctrl, apd_dp and the assertion header.
//
// Usage:
//  - Input stream (s_axis_*): one signed Q0.23 sample per transaction.
//  - Output stream (m_axis_*): one diffused, saturated sample per input.
//  - Config port: cfg_we_i writes cfg_data_i into register cfg_idx_i;
//    0..3 stage delays (11 bits), 4..7 stage gains (signed Q0.15).
//    Write only while no sample is in flight.
//  - Reset: all delay lines are cleared by a sweep over all STAGES*LINE_DEPTH
//    words (8192 at the defaults); s_axis_tready_o stays low meanwhile.
//  - Sequence: each stage runs index reduction, RAM read, d*g, subtract,
//    v*g with line write and add, all through one multiplier and one RAM
//    port pair. A new sample is taken only once the previous one has
//    passed all stages and entered the output register.
//  - Stall: the output register holds the finished sample; the next
//    input is accepted while it waits. The chain parks after its last
//    stage until the output register is free.
`default_nettype none

`include "allpass_diffuser_chain_assert.svh"

module allpass_diffuser_chain #(
  parameter int STAGES     = 4,
  parameter int LINE_DEPTH = 2048
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // configuration
  input  wire logic                              cfg_we_i,
  input  wire logic [apd_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [apd_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // input stream
  input  wire logic                              s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  input  wire logic [apd_pkg::SAMPLE_W-1:0]      s_axis_tdata_i,  // [23:0] sample_in
  // output stream
  output logic                                   m_axis_tvalid_o,
  input  wire logic                              m_axis_tready_i,
  output logic      [apd_pkg::SAMPLE_W-1:0]      m_axis_tdata_o   // [23:0] sample_out
);

  logic [STAGES-1:0][apd_pkg::DELAY_W-1:0] delay;
  logic [STAGES-1:0][apd_pkg::GAIN_W-1:0]  gain;
  apd_pkg::cmd_t cmd;
  apd_pkg::sts_t sts;

  apd_regs #(
    .STAGES (STAGES)
  ) u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .delay_o    (delay),
    .gain_o     (gain)
  );

  // sequencer: one sample at a time through all stages
  apd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  apd_dp #(
    .STAGES     (STAGES),
    .LINE_DEPTH (LINE_DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .sample_in_i  ($signed(s_axis_tdata_i)),
    .delay_i      (delay),
    .gain_i       (gain),
    .out_ready_i  (m_axis_tready_i),
    .out_valid_o  (m_axis_tvalid_o),
    .sample_out_o (m_axis_tdata_o)
  );

  // a finished sample never overwrites one still waiting
  `APD_ASSERT(a_load_out_free, cmd.load_out |-> (!m_axis_tvalid_o || m_axis_tready_i), "output overwritten while stalled")
  // no input taken while the delay lines are being cleared
  `APD_ASSERT(a_no_accept_clear, cmd.clr_wr |-> !s_axis_tready_o, "input ready during clearing pass")
  // after a transaction the chain is busy with that sample
  `APD_ASSERT(a_busy_after_accept, (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o, "accepted back to back")
  // an edge seen in reset clears the output valid by the next edge
  `APD_ASSERT_ALWAYS(a_no_out_in_reset, !rst_ni |=> !m_axis_tvalid_o, "output valid after reset")

endmodule

`default_nettype wire
